FILE: rtl/core/banded_frame_delay_slit_scan_defines.svh
// Assertion macros for the checker of the slit scan block.
// Each uses clk in its scope; all but BFDS_ASSERT_NEXT_NR use rst too.
`ifndef BANDED_FRAME_DELAY_SLIT_SCAN_DEFINES_SVH
`define BANDED_FRAME_DELAY_SLIT_SCAN_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define BFDS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slit scan check failed");

// Next-cycle implication, off while reset is high.
`define BFDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slit scan check failed");

// Next-cycle implication that also watches reset itself.
`define BFDS_ASSERT_NEXT_NR(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("slit scan check failed");

`endif

FILE: rtl/core/bfds_pkg.sv
package bfds_pkg;

  localparam int PIXEL_W    = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  // Field widths of the configuration registers as written on the bus
  localparam int CFG_NB_W  = 4;
  localparam int CFG_DIM_W = 9;

  localparam logic [REG_IDX_W-1:0] REG_NUM_BANDS    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

endpackage

FILE: rtl/core/banded_frame_delay_slit_scan.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   pixel
// output    out        out_valid / out_stall pixel_out, end_of_frame
// config    in         psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One item per cycle sustained while out_stall and clearing are low; an item passes
// through the s1, s2 and output registers. Each item costs one read and one write of the
// frame store in the same cycle. After reset the store is cleared one word a cycle, every
// slot, row and column address in turn, with in_stall high; configuration writes are taken.
// Output stall backs up through the three stages to in_stall in the same cycle.
module banded_frame_delay_slit_scan #(
  parameter int MAX_BANDS  = 8,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bfds_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bfds_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bfds_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bfds_pkg::PIXEL_W-1:0]     pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bfds_pkg::PIXEL_W-1:0]     pixel_out,
  output logic                             end_of_frame
);

  localparam int NB_W   = $clog2(MAX_BANDS+1);
  localparam int SLOT_W = $clog2(MAX_BANDS);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int W_W    = $clog2(MAX_WIDTH+1);
  localparam int H_W    = $clog2(MAX_HEIGHT+1);
  localparam int LIM_W  = $clog2(MAX_HEIGHT*MAX_BANDS+1);
  localparam int ADDR_W = SLOT_W + ROW_W + COL_W;
  localparam int DEPTH  = 2**ADDR_W;
  localparam int DW     = bfds_pkg::APB_DATA_W;
  localparam int PW     = bfds_pkg::PIXEL_W;

  // configuration
  logic [NB_W-1:0] num_bands;
  logic [W_W-1:0]  frame_width;
  logic [H_W-1:0]  frame_height;

  // raster position of the next item; lim = (row+1)*num_bands
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;
  logic [LIM_W-1:0]  lim;
  logic [SLOT_W-1:0] newest_slot;

  // store clearing after reset
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // pipeline
  logic              s1_v;
  logic [PW-1:0]     s1_pixel;
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  logic [LIM_W-1:0]  s1_lim;
  logic [SLOT_W-1:0] s1_newest;
  logic              s1_eof;
  logic              s2_v;
  logic [PW-1:0]     s2_pixel;
  logic              s2_live;
  logic              s2_eof;
  logic              out_v;
  logic [PW-1:0]     out_pixel;
  logic              out_eof;

  logic move_out, s2_free, move_s1, s1_free, in_acc;
  logic col_last, row_last, eof;

  logic [SLOT_W-1:0] band, slot;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [PW-1:0]     wdata, rdata;

  logic                           cfg_wr, cfg_known;
  logic [bfds_pkg::REG_IDX_W-1:0] reg_idx;
  logic [bfds_pkg::CFG_NB_W-1:0]  wr_nb;
  logic [bfds_pkg::CFG_DIM_W-1:0] wr_dim;
  logic [NB_W-1:0]                nb_new, nb_eff;
  logic [W_W-1:0]                 fw_new;
  logic [H_W-1:0]                 fh_new;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[bfds_pkg::APB_ADDR_W-1:2];
  assign wr_nb   = pwdata[bfds_pkg::CFG_NB_W-1:0];
  assign wr_dim  = pwdata[bfds_pkg::CFG_DIM_W-1:0];
  assign cfg_known = reg_idx inside {bfds_pkg::REG_NUM_BANDS, bfds_pkg::REG_FRAME_WIDTH,
                                     bfds_pkg::REG_FRAME_HEIGHT};

  // saturate written values into their legal ranges
  always_comb begin
    if (wr_nb == '0) begin
      nb_new = NB_W'(1);
    end else if (DW'(wr_nb) > DW'(MAX_BANDS)) begin
      nb_new = NB_W'(MAX_BANDS);
    end else begin
      nb_new = NB_W'(wr_nb);
    end
    if (wr_dim == '0) begin
      fw_new = W_W'(1);
      fh_new = H_W'(1);
    end else begin
      fw_new = (DW'(wr_dim) > DW'(MAX_WIDTH))  ? W_W'(MAX_WIDTH)  : W_W'(wr_dim);
      fh_new = (DW'(wr_dim) > DW'(MAX_HEIGHT)) ? H_W'(MAX_HEIGHT) : H_W'(wr_dim);
    end
  end

  assign nb_eff = (reg_idx == bfds_pkg::REG_NUM_BANDS) ? nb_new : num_bands;

  always_comb begin
    case (reg_idx)
      bfds_pkg::REG_NUM_BANDS:    prdata = DW'(num_bands);
      bfds_pkg::REG_FRAME_WIDTH:  prdata = DW'(frame_width);
      bfds_pkg::REG_FRAME_HEIGHT: prdata = DW'(frame_height);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  assign move_out  = out_v & ~out_stall;
  assign s2_free   = ~s2_v | ~out_v | ~out_stall;
  assign move_s1   = s1_v & s2_free;
  assign s1_free   = ~s1_v | s2_free;
  assign in_stall  = clearing | ~s1_free;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid    = out_v;
  assign pixel_out    = out_pixel;
  assign end_of_frame = out_eof;

  assign col_last = (W_W'(column) + W_W'(1)) >= frame_width;
  assign row_last = (H_W'(row) + H_W'(1)) >= frame_height;
  assign eof      = col_last & row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bands    <= NB_W'(1);
      frame_width  <= W_W'(MAX_WIDTH);
      frame_height <= H_W'(MAX_HEIGHT);
      column       <= '0;
      row          <= '0;
      lim          <= LIM_W'(1);
      newest_slot  <= '0;
      clearing     <= 1'b1;
      clr_addr     <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      if (cfg_wr && cfg_known) begin
        case (reg_idx)
          bfds_pkg::REG_NUM_BANDS:    num_bands    <= nb_new;
          bfds_pkg::REG_FRAME_WIDTH:  frame_width  <= fw_new;
          bfds_pkg::REG_FRAME_HEIGHT: frame_height <= fh_new;
          default:                    num_bands    <= num_bands;
        endcase
        // restart the raster; keep the store
        column <= '0;
        row    <= '0;
        lim    <= LIM_W'(nb_eff);
        if (NB_W'(newest_slot) >= nb_eff) begin
          newest_slot <= '0;
        end
      end else if (in_acc) begin
        if (col_last) begin
          column <= '0;
          if (row_last) begin
            row <= '0;
            lim <= LIM_W'(num_bands);
          end else begin
            row <= row + ROW_W'(1);
            lim <= lim + LIM_W'(num_bands);
          end
        end else begin
          column <= column + COL_W'(1);
        end
        // step the newest slot back after each frame
        if (eof) begin
          newest_slot <= (newest_slot == '0) ? SLOT_W'(num_bands - NB_W'(1))
                                             : newest_slot - SLOT_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v <= in_acc;
      end
      if (s2_free) begin
        s2_v <= move_s1;
      end
      if (~out_v | ~out_stall) begin
        out_v <= s2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel  <= pixel;
      s1_row    <= row;
      s1_col    <= column;
      s1_lim    <= lim;
      s1_newest <= newest_slot;
      s1_eof    <= eof;
    end
    if (move_s1) begin
      s2_pixel <= s1_pixel;
      s2_live  <= (band == '0);
      s2_eof   <= s1_eof;
    end
    if (move_out) begin
      out_pixel <= s2_live ? s2_pixel : rdata;
      out_eof   <= s2_eof;
    end else if (~out_v) begin
      out_pixel <= s2_live ? s2_pixel : rdata;
      out_eof   <= s2_eof;
    end
  end

  bfds_band #(
    .MAX_BANDS  (MAX_BANDS),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_band (
    .frame_height (frame_height),
    .num_bands    (num_bands),
    .lim          (s1_lim),
    .newest       (s1_newest),
    .band         (band),
    .slot         (slot)
  );

  // An item writes the newest slot and reads slot (band + newest) mod n; for band 0 that
  // is the same word and the live pixel is used. A word written by one item is read back
  // no earlier than the next edge, when the write has landed, so no forwarding is needed.
  assign re    = move_s1;
  assign raddr = {slot, s1_row, s1_col};
  assign we    = clearing | move_s1;
  assign waddr = clearing ? clr_addr : {s1_newest, s1_row, s1_col};
  assign wdata = clearing ? '0 : s1_pixel;

  bfds_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

FILE: rtl/core/bfds_ram.sv
module bfds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the read data while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/bfds_band.sv
module bfds_band #(
  parameter int MAX_BANDS  = 8,
  parameter int MAX_HEIGHT = 256
) (
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]           frame_height,
  input  logic [$clog2(MAX_BANDS+1)-1:0]            num_bands,
  input  logic [$clog2(MAX_HEIGHT*MAX_BANDS+1)-1:0] lim,
  input  logic [$clog2(MAX_BANDS)-1:0]              newest,
  output logic [$clog2(MAX_BANDS)-1:0]              band,
  output logic [$clog2(MAX_BANDS)-1:0]              slot
);

  localparam int NB_W   = $clog2(MAX_BANDS+1);
  localparam int SLOT_W = $clog2(MAX_BANDS);
  localparam int LIM_W  = $clog2(MAX_HEIGHT*MAX_BANDS+1);
  localparam int SUM_W  = NB_W + 1;

  logic [SUM_W-1:0] sum;

  // Row y is in band i when floor(h*i/n) <= y, i.e. h*i < (y+1)*n = lim.
  // The boundaries rise with i, so the last band that passes wins.
  always_comb begin
    logic [LIM_W-1:0] prod;
    prod = '0;
    band = '0;
    for (int i = 1; i < MAX_BANDS; i++) begin
      prod = LIM_W'(frame_height) * LIM_W'(i);
      if ((NB_W'(i) < num_bands) && (prod < lim)) begin
        band = SLOT_W'(i);
      end
    end
  end

  // (band + newest) mod n; both are below n, so one subtract is enough
  assign sum  = SUM_W'(band) + SUM_W'(newest);
  assign slot = (sum >= SUM_W'(num_bands)) ? SLOT_W'(sum - SUM_W'(num_bands))
                                           : SLOT_W'(sum);

endmodule

FILE: rtl/core/bfds_check.sv
`include "banded_frame_delay_slit_scan_defines.svh"

module bfds_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [bfds_pkg::APB_ADDR_W-1:0] paddr,
  input logic [bfds_pkg::APB_DATA_W-1:0] prdata,
  input logic                            pready,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [bfds_pkg::PIXEL_W-1:0]    pixel_out,
  input logic                            end_of_frame
);

  logic       in_acc, out_acc, cfg_wr;
  logic [2:0] inflight;

  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;
  assign cfg_wr  = psel & penable & pwrite & pready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(in_acc) - 3'(out_acc);
    end
  end

  `BFDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(pixel_out) && $stable(end_of_frame))
  `BFDS_ASSERT_IMP(a_no_invent, out_valid, inflight != 3'd0)
  `BFDS_ASSERT_IMP(a_depth, !cfg_wr || cfg_wr, inflight <= 3'd3)
  `BFDS_ASSERT_IMP(a_bands_nonzero, psel && (paddr[3:2] == bfds_pkg::REG_NUM_BANDS),
                   prdata != '0)
  `BFDS_ASSERT_NEXT_NR(a_clear_after_reset, rst, in_stall)

endmodule

bind banded_frame_delay_slit_scan bfds_check u_bfds_check (.*);
